>>> rtl/core/ubvc_pkg.sv
// Shared constants, payload types and pipeline record for the baud value calculator.
package ubvc_pkg;

	localparam int FRACTION_BITS   = 32;
	localparam int BAUD_W          = 28;
	localparam int CLK_W           = 32;
	localparam int SAMPLES_W       = 5;
	localparam int VALUE_W         = 16;
	localparam int PROD_W          = SAMPLES_W + BAUD_W;
	localparam int WORD_W          = 64;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = WORD_W / STEPS_PER_STAGE;

	localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = SAMPLES_W'(16);

	typedef struct packed {
		logic [BAUD_W-1:0] baud_rate;
		logic [CLK_W-1:0]  clock_hz;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] baud_reg;
		logic               out_of_range;
	} res_t;

	// The word holds numerator bits still to shift out at the top and quotient
	// bits shifted in at the bottom.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CLK_W-1:0]  rem;
		logic [CLK_W-1:0]  den;
		logic              flag;
	} div_t;

endpackage

>>> rtl/core/ubvc_front.sv
// Front stage: oversampling register, product, numerator and range flag.
module ubvc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  ubvc_pkg::req_t           request,
	input  logic                     cfg_we,
	input  logic [ubvc_pkg::SAMPLES_W-1:0] cfg_wdata,
	output logic                     valid_s1,
	output ubvc_pkg::div_t           data_s1
);
	import ubvc_pkg::*;

	logic [SAMPLES_W-1:0] samples_q;
	logic [PROD_W-1:0]    prod;
	logic [WORD_W-1:0]    num;
	logic                 flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= SAMPLES_RESET;
		end else if (cfg_we) begin
			samples_q <= cfg_wdata;
		end
	end

	always_comb begin
		prod = PROD_W'(samples_q) * PROD_W'(request.baud_rate);
		num  = WORD_W'(prod) << FRACTION_BITS;
		flag = (request.clock_hz == '0) || (prod > PROD_W'(request.clock_hz));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.word <= num;
		data_s1.rem  <= '0;
		data_s1.den  <= request.clock_hz;
		data_s1.flag <= flag;
	end

endmodule

>>> rtl/core/ubvc_div_stage.sv
// One registered slice of the restoring divider, a few quotient bits per stage.
module ubvc_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	input  ubvc_pkg::div_t data_in,
	output logic           valid_s1,
	output ubvc_pkg::div_t data_s1
);
	import ubvc_pkg::*;

	logic [WORD_W-1:0] word;
	logic [CLK_W-1:0]  rem;
	logic [CLK_W:0]    trial;

	always_comb begin
		word  = data_in.word;
		rem   = data_in.rem;
		trial = '0;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			trial = {rem, word[WORD_W-1]};
			word  = {word[WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, data_in.den}) begin
				trial   = trial - {1'b0, data_in.den};
				word[0] = 1'b1;
			end
			rem = trial[CLK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.word <= word;
		data_s1.rem  <= rem;
		data_s1.den  <= data_in.den;
		data_s1.flag <= data_in.flag;
	end

endmodule

>>> rtl/core/ubvc_back.sv
// Back stage: scale from the ratio, baud value extraction and result register.
module ubvc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	input  ubvc_pkg::div_t data_in,
	output logic           done,
	output ubvc_pkg::res_t result
);
	import ubvc_pkg::*;

	localparam logic [WORD_W-1:0] ONE_FIXED = WORD_W'(1) << FRACTION_BITS;

	logic [WORD_W-1:0] scale;
	logic [WORD_W-1:0] scale_sh;

	always_comb begin
		scale    = ONE_FIXED - data_in.word;
		scale_sh = scale << VALUE_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		result.baud_reg     <= scale_sh[FRACTION_BITS +: VALUE_W];
		result.out_of_range <= data_in.flag;
	end

endmodule

>>> rtl/core/uart_async_baud_value_calc.sv
// Top level of the pipelined asynchronous UART baud value calculator.
//
//   beat        | ports                       | handshake
//   ------------+-----------------------------+---------------------------
//   request     | request (baud, clock)       | start high, busy low
//   result      | result (value, flag)        | done high for one cycle
//   oversampling| cfg_wdata                   | cfg_we high
//
// A new request beat may enter on every cycle; busy is always low.
// Each result passes through one front stage, sixteen divider stages of four
// restoring steps each, and one output stage.
// Reset clears the valid bits and sets the oversampling count to sixteen.
// The pipeline never stalls; the receiver must take every result beat.
module uart_async_baud_value_calc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ubvc_pkg::req_t                 request,
	output logic                           done,
	output ubvc_pkg::res_t                 result,
	input  logic                           cfg_we,
	input  logic [ubvc_pkg::SAMPLES_W-1:0] cfg_wdata
);
	import ubvc_pkg::*;

	logic valid_chain [0:DIV_STAGES];
	div_t data_chain  [0:DIV_STAGES];

	assign busy = 1'b0;

	ubvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_chain[0]),
		.data_s1   (data_chain[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ubvc_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_chain[g]),
			.data_in  (data_chain[g]),
			.valid_s1 (valid_chain[g+1]),
			.data_s1  (data_chain[g+1])
		);
	end

	ubvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_chain[DIV_STAGES]),
		.data_in  (data_chain[DIV_STAGES]),
		.done     (done),
		.result   (result)
	);

endmodule
